### sv/ciss_pkg.sv
// ----------------------------------------------------------------------------
// ciss_pkg: shared types and helpers for the substring search core
// Byte compare with ASCII case folding, register codes, cell control.
// ----------------------------------------------------------------------------
package ciss_pkg;

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int PATTERN_REG_BYTES   = 16;  // bytes held by the two pattern registers
  localparam int CFG_W               = 64;
  localparam int LEN_W               = 5;
  localparam int POS_W               = 8;   // covers cell positions and lengths

  localparam logic [7:0] CASE_BIT       = 8'h20;
  localparam logic [7:0] FOLD_MASK      = ~CASE_BIT;
  localparam logic [7:0] BYTE_MASK      = 8'hff;
  localparam logic [7:0] LETTER_FIRST   = 8'h41;
  localparam logic [7:0] LETTER_LAST    = 8'h5a;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } ciss_reg_t;

  typedef struct packed {
    logic             shift;   // accepted item that is not the last of its text
    logic             len_ok;  // pattern length in 1..MAX_PATTERN
    logic [LEN_W-1:0] len;
  } ciss_cell_ctrl_t;

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] u;
    u = c & FOLD_MASK;
    return (u >= LETTER_FIRST) && (u <= LETTER_LAST);
  endfunction

  // Case bit is ignored only when the text byte is a letter.
  function automatic logic bytes_match(input logic [7:0] t, input logic [7:0] p);
    logic [7:0] mask;
    mask = is_letter(t) ? FOLD_MASK : BYTE_MASK;
    return ((t ^ p) & mask) == 8'h00;
  endfunction

endpackage

### sv/ciss_text_if.sv
// ----------------------------------------------------------------------------
// ciss_text_if: text byte channel
// Valid/ready channel carrying one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface ciss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source(output valid, output text_byte, output last_byte, input ready);
  modport sink(input valid, input text_byte, input last_byte, output ready);
endinterface

### sv/ciss_result_if.sv
// ----------------------------------------------------------------------------
// ciss_result_if: search result channel
// Valid/ready channel carrying the found flag of one finished text.
// ----------------------------------------------------------------------------
interface ciss_result_if;
  logic valid;
  logic ready;
  logic found;

  modport source(output valid, output found, input ready);
  modport sink(input valid, input found, output ready);
endinterface

### sv/ciss_cell.sv
// ----------------------------------------------------------------------------
// ciss_cell: one window position of the search chain
// Holds one past text byte, passes it on each shift and compares it with
// the pattern byte that lines up with it for the current pattern length.
// ----------------------------------------------------------------------------
module ciss_cell #(
  parameter int MAX_PATTERN = ciss_pkg::MAX_PATTERN_DEFAULT,
  parameter int POSITION    = 0
) (
  input  logic                          clk,
  input  ciss_pkg::ciss_cell_ctrl_t     ctrl,
  input  logic [MAX_PATTERN*8-1:0]      pattern,
  input  logic [7:0]                    byte_in,
  output logic [7:0]                    byte_out,
  output logic                          ok
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [ciss_pkg::POS_W-1:0] NEXT_POS = ciss_pkg::POS_W'(POSITION + 1);
  localparam logic [ciss_pkg::POS_W-1:0] PAT_OFS  = ciss_pkg::POS_W'(POSITION + 2);

  logic [7:0]                   window_byte;
  logic [ciss_pkg::POS_W-1:0]   len_wide;
  logic [ciss_pkg::POS_W-1:0]   pat_pos;
  logic [IDX_W-1:0]             sel;
  logic                         active;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      window_byte <= byte_in;
    end
  end

  // This cell holds the byte POSITION+1 places back; it lines up with
  // pattern byte len-2-POSITION.
  always_comb begin
    len_wide = ciss_pkg::POS_W'(ctrl.len);
    active   = ctrl.len_ok && (NEXT_POS < len_wide);
    pat_pos  = len_wide - PAT_OFS;
    sel      = active ? IDX_W'(pat_pos) : '0;
    ok       = !active || ciss_pkg::bytes_match(window_byte, pattern[sel*8 +: 8]);
  end

  assign byte_out = window_byte;

endmodule

### sv/case_insensitive_substring_search_core.sv
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_core: streaming pattern search
// Reports per text whether a pattern of up to 16 bytes occurs, ASCII
// letters compared without regard to case.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one text byte per item, last_byte marks the end of a text.
//   result : one item per text, found = 1 if the pattern occurred in it.
//   cfg_*  : write port for pattern_bytes_low (0), pattern_bytes_high (1)
//            and pattern_length (2); write between texts or between bytes.
// A chain of MAX_PATTERN-1 cells holds the recent bytes; every cycle each
// cell compares its byte against the aligned pattern byte and the incoming
// byte is checked against the final pattern byte, so one byte is taken per
// cycle while text.ready is high. The output register loads the result when
// the last byte is accepted. Throughput is one item per cycle while the result
// channel keeps up; the output register is the only stage, so text.ready
// drops while a result waits and result.ready is low.
// Reset (rst, synchronous) clears the pattern registers, byte count, match
// flag and output valid; a zero pattern length never produces a hit.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_core #(
  parameter int MAX_PATTERN = ciss_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  ciss_text_if.sink                   text,
  ciss_result_if.source               result,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [ciss_pkg::CFG_W-1:0]  cfg_data
);

  localparam int NCELL  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W  = ((SEEN_W > ciss_pkg::LEN_W) ? SEEN_W : ciss_pkg::LEN_W) + 1;

  logic [ciss_pkg::CFG_W-1:0]   pat_low;
  logic [ciss_pkg::CFG_W-1:0]   pat_high;
  logic [ciss_pkg::LEN_W-1:0]   pat_len;
  logic [SEEN_W-1:0]            bytes_seen;
  logic                         match_seen;
  logic                         out_valid;
  logic                         out_found;

  logic [MAX_PATTERN*8-1:0]     pattern_vec;
  ciss_pkg::ciss_cell_ctrl_t    ctrl;
  logic [7:0]                   chain [NCELL+1];
  logic [NCELL-1:0]             cell_ok;
  logic                         accept;
  logic                         len_ok;
  logic                         seen_ok;
  logic [ciss_pkg::LEN_W-1:0]   len_m1;
  logic [IDX_W-1:0]             head_idx;
  logic                         head_ok;
  logic                         hit;
  logic                         match_now;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= '0;
    end else if (cfg_write) begin
      unique case (ciss_pkg::ciss_reg_t'(cfg_index))
        ciss_pkg::REG_PATTERN_LOW:    pat_low  <= cfg_data;
        ciss_pkg::REG_PATTERN_HIGH:   pat_high <= cfg_data;
        ciss_pkg::REG_PATTERN_LENGTH: pat_len  <= cfg_data[ciss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pattern positions beyond the two registers read as zero.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < ciss_pkg::PATTERN_REG_BYTES / 2) begin : g_low
      assign pattern_vec[k*8 +: 8] = pat_low[k*8 +: 8];
    end else if (k < ciss_pkg::PATTERN_REG_BYTES) begin : g_high
      assign pattern_vec[k*8 +: 8] =
        pat_high[(k - ciss_pkg::PATTERN_REG_BYTES / 2)*8 +: 8];
    end else begin : g_zero
      assign pattern_vec[k*8 +: 8] = 8'h00;
    end
  end

  assign text.ready = !out_valid || result.ready;
  assign accept     = text.valid && text.ready;

  always_comb begin
    len_ok   = (pat_len != '0) && (CMP_W'(pat_len) <= CMP_W'(MAX_PATTERN));
    seen_ok  = (CMP_W'(bytes_seen) + CMP_W'(1)) >= CMP_W'(pat_len);
    len_m1   = pat_len - ciss_pkg::LEN_W'(1);
    head_idx = len_ok ? IDX_W'(len_m1) : '0;
    head_ok  = ciss_pkg::bytes_match(text.text_byte, pattern_vec[head_idx*8 +: 8]);
    hit      = len_ok && seen_ok && head_ok && (&cell_ok);
    match_now = match_seen || hit;

    ctrl.shift  = accept && !text.last_byte;
    ctrl.len_ok = len_ok;
    ctrl.len    = pat_len;
  end

  assign chain[0] = text.text_byte;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    ciss_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .POSITION    (c)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pattern  (pattern_vec),
      .byte_in  (chain[c]),
      .byte_out (chain[c+1]),
      .ok       (cell_ok[c])
    );
  end

  // Per-text state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && text.last_byte) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (text.last_byte) begin
          bytes_seen <= '0;
          match_seen <= 1'b0;
        end else begin
          match_seen <= match_now;
          if (bytes_seen != SEEN_W'(MAX_PATTERN)) begin
            bytes_seen <= bytes_seen + SEEN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.last_byte) begin
      out_found <= match_now;
    end
  end

  assign result.valid = out_valid;
  assign result.found = out_found;

  // Checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && text.last_byte |=> result.valid)
    else $error("last item did not load a result");

  a_text_state_clears: assert property (@(posedge clk) disable iff (rst)
    accept && text.last_byte |=> (bytes_seen == '0) && !match_seen)
    else $error("per-text state not cleared after last item");

  a_empty_never_found: assert property (@(posedge clk) disable iff (rst)
    accept && text.last_byte && (pat_len == '0) && !match_seen |=> !result.found)
    else $error("empty pattern reported found");

  a_seen_saturates: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(bytes_seen) <= CMP_W'(MAX_PATTERN))
    else $error("byte count beyond saturation");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !text.ready)
    else $error("input taken while result stalled");

endmodule

### dv/tb_case_insensitive_substring_search_core.sv
// ----------------------------------------------------------------------------
// tb_case_insensitive_substring_search_core: self-checking bench
// Streams texts into the search core and compares each per-text found flag
// with a local window predictor. A directed table covers reset state, case
// folding, high bytes, short text, empty and overlong lengths, a change of
// pattern inside a text and a full 16-byte pattern. Random texts with the
// pattern embedded, damaged or absent follow, under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_case_insensitive_substring_search_core;

  localparam int          WIN_DEPTH    = 15;  // bytes kept behind the current one
  localparam int          PAT_MAX      = 16;
  localparam int          NO_TYPED     = -1;
  localparam int          SETTLE_CYC   = 6;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          ITEMS_PER_PAT = 40;
  localparam logic [7:0]  CASE_FLIP    = 8'h20;
  localparam logic [7:0]  UPPER_MASK   = 8'hdf;

  typedef enum logic { ROW_TEXT, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [7:0]  tbyte;
    logic        lastb;
    int          want;    // NO_TYPED: take the predictor's answer
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  ciss_pkg::ciss_reg_t cfg_index;
  logic [ciss_pkg::CFG_W-1:0] cfg_data;

  ciss_text_if   text_ch();
  ciss_result_if result_ch();

  case_insensitive_substring_search_core DUT (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state and its copy of the registers
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0]  pat_len = '0;
  logic [7:0]  hist_bytes [WIN_DEPTH];
  int unsigned bytes_in_text = 0;
  logic        hit_in_text = 1'b0;

  logic        pending_found [$];
  int          typed_found;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          err_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [7:0] pat_byte(input int unsigned k);
    if (k < 8) return pat_lo[8*k +: 8];
    if (k < 16) return pat_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  // case is ignored only when the text byte is an ASCII letter
  function automatic logic folded_eq(input logic [7:0] t, input logic [7:0] p);
    logic [7:0] u;
    logic [7:0] m;
    u = t & UPPER_MASK;
    m = (u >= 8'h41 && u <= 8'h5a) ? UPPER_MASK : 8'hff;
    return ((t ^ p) & m) == 8'h00;
  endfunction

  // Advances the predictor by one byte; returns 1 when a result is due.
  function automatic logic search_step(input logic [7:0] cur, input logic lastb,
                                       output logic found);
    int unsigned len;
    logic ok;
    len = pat_len;
    found = 1'b0;
    if (len >= 1 && len <= PAT_MAX && bytes_in_text + 1 >= len) begin
      ok = folded_eq(cur, pat_byte(len - 1));
      for (int unsigned i = 1; i < len; i++)
        if (!folded_eq(hist_bytes[i-1], pat_byte(len - 1 - i))) ok = 1'b0;
      if (ok) hit_in_text = 1'b1;
    end
    if (lastb) begin
      found = hit_in_text;
      foreach (hist_bytes[i]) hist_bytes[i] = 8'h00;
      bytes_in_text = 0;
      hit_in_text = 1'b0;
      return 1'b1;
    end
    for (int i = WIN_DEPTH - 1; i > 0; i--) hist_bytes[i] = hist_bytes[i-1];
    hist_bytes[0] = cur;
    if (bytes_in_text < PAT_MAX) bytes_in_text++;
    return 1'b0;
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] p);
    logic [7:0] u;
    u = p & UPPER_MASK;
    if ($urandom_range(15) == 0) return p ^ CASE_FLIP;  // near miss on non-letters
    if (u >= 8'h41 && u <= 8'h5a && $urandom_range(1)) return p ^ CASE_FLIP;
    return p;
  endfunction

  function automatic stim_row_t trow(input logic [7:0] b, input logic l, input int w);
    stim_row_t r;
    r = '{ROW_TEXT, 64'h0, 64'h0, 5'd0, b, l, w};
    return r;
  endfunction

  function automatic stim_row_t crow(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [4:0] len);
    stim_row_t r;
    r = '{ROW_CFG, lo, hi, len, 8'h00, 1'b0, NO_TYPED};
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : monitor_b
    logic f;
    logic e;
    if (!rst) begin
      if (text_ch.valid === 1'b1 && text_ch.ready === 1'b1) begin
        if (search_step(text_ch.text_byte, text_ch.last_byte, f)) begin
          if (typed_found != NO_TYPED) f = typed_found[0];
          pending_found.push_back(f);
        end
      end
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (pending_found.size() == 0) begin
          $error("found: expected none, actual %0b", result_ch.found);
          err_count++;
        end else begin
          e = pending_found.pop_front();
          if (result_ch.found !== e) begin
            $error("found: expected %0b, actual %0b", e, result_ch.found);
            err_count++;
          end
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l, input int w);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.last_byte <= l;
    typed_found       <= w;
    @(posedge clk);
    while (text_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // hold the sender until every result is back and the core has gone quiet
  task automatic settle();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_found.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len);
    cfg_write <= 1'b1;
    cfg_index <= ciss_pkg::REG_PATTERN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= ciss_pkg::REG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= ciss_pkg::REG_PATTERN_LENGTH;
    cfg_data  <= ciss_pkg::CFG_W'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
    pat_lo  = lo;
    pat_hi  = hi;
    pat_len = len;
  endtask

  initial begin : main_b
    stim_row_t   rows [$];
    logic [7:0]  pb [PAT_MAX];
    logic [7:0]  txt [40];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  plen;
    int          pick;
    int          shape;
    int          tlen;
    int          pos;
    int          sent;

    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= 8'h00;
    text_ch.last_byte <= 1'b0;
    typed_found       <= NO_TYPED;
    cfg_write         <= 1'b0;
    cfg_index         <= ciss_pkg::REG_PATTERN_LOW;
    cfg_data          <= '0;
    foreach (hist_bytes[i]) hist_bytes[i] = 8'h00;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty pattern straight out of reset
    rows.push_back(trow(8'h41, 1'b1, 0));
    rows.push_back(crow(64'h6261, 64'h0, 5'd2));          // "ab"
    rows.push_back(trow(8'h61, 1'b1, 0));                 // text shorter than pattern
    rows.push_back(trow(8'h78, 1'b0, NO_TYPED));
    rows.push_back(trow(8'h41, 1'b0, NO_TYPED));
    rows.push_back(trow(8'h42, 1'b0, NO_TYPED));          // "AB" hits, text goes on
    rows.push_back(crow(64'h80, 64'h0, 5'd1));            // new pattern inside the text
    rows.push_back(trow(8'ha0, 1'b1, NO_TYPED));          // earlier hit must survive
    rows.push_back(trow(8'h80, 1'b1, 1));
    rows.push_back(crow(64'h80, 64'h0, 5'd31));           // length past the maximum
    rows.push_back(trow(8'h80, 1'b1, 0));
    rows.push_back(crow('1, '1, 5'd16));
    for (int i = 0; i < 15; i++) rows.push_back(trow(8'hff, 1'b0, NO_TYPED));
    rows.push_back(trow(8'hff, 1'b1, 1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        set_pattern(rows[i].lo, rows[i].hi, rows[i].len);
      end else begin
        send_item(rows[i].tbyte, rows[i].lastb, rows[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int s = 0; s < 4; s++) begin
        pick = $urandom_range(9);
        if (ph == 0 && s == 0) plen = 5'd16;
        else if (pick == 0) plen = 5'd0;
        else if (pick == 1) plen = 5'd16;
        else if (pick == 2) plen = 5'($urandom_range(17, 31));
        else plen = 5'($urandom_range(1, 6));
        // half the bytes are one of four letters so random text lands close to the pattern
        for (int k = 0; k < PAT_MAX; k++)
          pb[k] = $urandom_range(1) ? (8'(8'h61 + $urandom_range(3)) ^
                                       8'($urandom_range(1) << 5))
                                    : 8'($urandom_range(255));
        for (int k = 0; k < 8; k++) begin
          lo[8*k +: 8] = pb[k];
          hi[8*k +: 8] = pb[k+8];
        end
        settle();
        set_pattern(lo, hi, plen);

        sent = 0;
        while (sent < ITEMS_PER_PAT) begin
          tlen = ($urandom_range(7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 20);
          for (int j = 0; j < tlen; j++)
            txt[j] = $urandom_range(1) ? vary_case(pb[$urandom_range(PAT_MAX - 1)])
                                       : 8'($urandom_range(255));
          shape = $urandom_range(9);
          if (plen >= 1 && plen <= PAT_MAX && tlen >= plen && shape < 7) begin
            pos = $urandom_range(tlen - plen);
            for (int j = 0; j < plen; j++) txt[pos + j] = vary_case(pb[j]);
            if (shape >= 5)   // damaged copy
              txt[pos + $urandom_range(plen - 1)] ^= 8'(1 << $urandom_range(7));
          end
          for (int j = 0; j < tlen; j++) begin
            send_item(txt[j], j == tlen - 1, NO_TYPED);
            sent++;
          end
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
